### hw/rtl/smx_pkg.sv
// Package: shared constants, datapath operation codes and control/status structs.
`timescale 1ns / 1ps
package smx_pkg;

  localparam int unsigned MaxClassesDef = 16;
  localparam logic [4:0]  NumClassesRst = 5'd2;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_BOOT_INIT,
    OP_SER_MUL_DIV,
    OP_SER_ACC,
    OP_CLAMP,
    OP_E1_SQ,
    OP_POW,
    OP_EXP_RD,
    OP_EXP_LD,
    OP_EXP_WR,
    OP_PROB_RD,
    OP_PROB_START,
    OP_EMIT
  } smx_op_e;

  typedef struct packed {
    smx_op_e op;
  } smx_cmd_t;

  typedef struct packed {
    logic inst_done;  // the incoming word completes an instance
    logic div_idle;   // divider holds no work
    logic k_last;     // series is on its final term
    logic n_big;      // integer part of the difference is 32 or more
    logic pow_done;   // all exp(-1) products are applied
    logic cls_last;   // class pointer is on the last class
  } smx_status_t;

endpackage

### hw/rtl/smx_ctrl.sv
// Controller: one-hot sequencer that steps the datapath through each instance.
`timescale 1ns / 1ps
module smx_ctrl
  import smx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  smx_status_t status_i,
  output smx_cmd_t    cmd_o,
  output logic        busy
);

  typedef enum logic [12:0] {
    S_BOOT     = 13'b0000000000001,
    S_SER_MUL  = 13'b0000000000010,
    S_SER_DIV  = 13'b0000000000100,
    S_SER_END  = 13'b0000000001000,
    S_E1       = 13'b0000000010000,
    S_POW      = 13'b0000000100000,
    S_IDLE     = 13'b0000001000000,
    S_EXP_RD   = 13'b0000010000000,
    S_EXP_LD   = 13'b0000100000000,
    S_EXP_WR   = 13'b0001000000000,
    S_PROB_RD  = 13'b0010000000000,
    S_PROB_LD  = 13'b0100000000000,
    S_PROB_DIV = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   boot_q, boot_d;

  always_comb begin
    state_d    = state_q;
    boot_d     = boot_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_BOOT: begin
        cmd_o.op = OP_BOOT_INIT;
        state_d  = S_SER_MUL;
      end
      S_SER_MUL: begin
        if (status_i.n_big && !boot_q) begin
          state_d = S_EXP_WR;
        end else begin
          cmd_o.op = OP_SER_MUL_DIV;
          state_d  = S_SER_DIV;
        end
      end
      S_SER_DIV: begin
        if (status_i.div_idle) begin
          cmd_o.op = OP_SER_ACC;
          state_d  = status_i.k_last ? S_SER_END : S_SER_MUL;
        end
      end
      S_SER_END: begin
        cmd_o.op = OP_CLAMP;
        state_d  = boot_q ? S_E1 : S_POW;
      end
      S_E1: begin
        cmd_o.op = OP_E1_SQ;
        boot_d   = 1'b0;
        state_d  = S_IDLE;
      end
      S_POW: begin
        if (status_i.pow_done) begin
          state_d = S_EXP_WR;
        end else begin
          cmd_o.op = OP_POW;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_ACCEPT;
          if (status_i.inst_done) begin
            state_d = S_EXP_RD;
          end
        end
      end
      S_EXP_RD: begin
        cmd_o.op = OP_EXP_RD;
        state_d  = S_EXP_LD;
      end
      S_EXP_LD: begin
        cmd_o.op = OP_EXP_LD;
        state_d  = S_SER_MUL;
      end
      S_EXP_WR: begin
        cmd_o.op = OP_EXP_WR;
        state_d  = status_i.cls_last ? S_PROB_RD : S_EXP_RD;
      end
      S_PROB_RD: begin
        cmd_o.op = OP_PROB_RD;
        state_d  = S_PROB_LD;
      end
      S_PROB_LD: begin
        cmd_o.op = OP_PROB_START;
        state_d  = S_PROB_DIV;
      end
      S_PROB_DIV: begin
        if (status_i.div_idle) begin
          cmd_o.op = OP_EMIT;
          state_d  = status_i.cls_last ? S_IDLE : S_PROB_RD;
        end
      end
      default: begin
        state_d = S_BOOT;
        boot_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      boot_q  <= boot_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hw/rtl/smx_datapath.sv
// Datapath: score and exponential stores, series unit, shared divider, result register.
`timescale 1ns / 1ps
module smx_datapath
  import smx_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MaxClassesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smx_cmd_t           cmd_i,
  output smx_status_t        status_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic signed [15:0] score_i,
  output logic               result_valid_o,
  output logic [15:0]        probability_o,
  output logic [3:0]         class_index_o,
  output logic               last_class_o
);

  localparam int unsigned AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned RW = $clog2(MAX_CLASSES + 1);
  localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

  // Stores
  logic [15:0] score_mem [MAX_CLASSES];
  logic [25:0] exp_mem   [MAX_CLASSES];
  logic [15:0] rd_score_q;
  logic [25:0] rd_exp_q;

  logic [4:0]         num_classes_q;
  logic [RW-1:0]      recv_q, recv_d;
  logic [AW-1:0]      cls_q, cls_d;
  logic signed [15:0] largest_q, largest_d;
  logic [31:0]        sum_q, sum_d;

  // Series and power unit
  logic signed [34:0] acc_q, acc_d;
  logic [32:0]        term_q, term_d;
  logic [32:0]        v_q, v_d;
  logic [31:0]        e1_q, e1_d;
  logic [7:0]         m_q, m_d;
  logic [4:0]         k_q, k_d;
  logic [7:0]         n_q, n_d;
  logic [4:0]         pow_q, pow_d;

  // Shared restoring divider
  logic [41:0] div_num_q, div_num_d;
  logic [31:0] div_den_q, div_den_d;
  logic [31:0] div_rem_q, div_rem_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic [32:0] div_trial;
  logic        div_fit;

  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod;
  logic [RW-1:0]      count;
  logic [RW-1:0]      recv_inc;
  logic               cls_last;
  logic signed [16:0] diff;
  logic [32:0]        quo;

  logic        res_valid_q, res_valid_d;
  logic [15:0] prob_q, prob_d;
  logic [3:0]  cidx_q, cidx_d;
  logic        last_q, last_d;

  // Clamp the configured class count.
  always_comb begin
    if (num_classes_q < 5'd2) begin
      count = RW'(2);
    end else if (int'(num_classes_q) > int'(MAX_CLASSES)) begin
      count = RW'(MAX_CLASSES);
    end else begin
      count = RW'(num_classes_q);
    end
  end

  assign recv_inc = recv_q + RW'(1);
  assign cls_last = ((RW'(cls_q) + RW'(1)) == count);
  assign diff     = 17'(largest_q) - 17'(signed'(rd_score_q));
  assign quo      = div_num_q[32:0];

  always_comb begin
    mul_a = term_q;
    mul_b = {25'd0, m_q};
    case (cmd_i.op)
      OP_POW: begin
        mul_a = v_q;
        mul_b = {1'b0, e1_q};
      end
      OP_E1_SQ: begin
        mul_a = v_q;
        mul_b = v_q;
      end
      default: begin
        mul_a = term_q;
        mul_b = {25'd0, m_q};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign div_trial = {div_rem_q, div_num_q[41]};
  assign div_fit   = (div_trial >= {1'b0, div_den_q});

  always_comb begin
    recv_d      = recv_q;
    cls_d       = cls_q;
    largest_d   = largest_q;
    sum_d       = sum_q;
    acc_d       = acc_q;
    term_d      = term_q;
    v_d         = v_q;
    e1_d        = e1_q;
    m_d         = m_q;
    k_d         = k_q;
    n_d         = n_q;
    pow_d       = pow_q;
    div_num_d   = div_num_q;
    div_den_d   = div_den_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    res_valid_d = 1'b0;
    prob_d      = prob_q;
    cidx_d      = cidx_q;
    last_d      = last_q;

    // Advance the divider one quotient bit a cycle.
    if (div_cnt_q != 6'd0) begin
      div_rem_d = div_fit ? 32'(div_trial - {1'b0, div_den_q}) : div_trial[31:0];
      div_num_d = {div_num_q[40:0], div_fit};
      div_cnt_d = div_cnt_q - 6'd1;
    end

    case (cmd_i.op)
      OP_ACCEPT: begin
        if (score_i > largest_q) begin
          largest_d = score_i;
        end
        if (recv_inc >= count) begin
          recv_d = '0;
          cls_d  = '0;
          sum_d  = '0;
        end else begin
          recv_d = recv_inc;
        end
      end
      OP_BOOT_INIT: begin
        acc_d  = 35'(OneQ32);
        term_d = OneQ32;
        k_d    = 5'd1;
        m_d    = 8'd128;
      end
      OP_EXP_LD: begin
        n_d    = diff[15:8];
        m_d    = diff[7:0];
        acc_d  = 35'(OneQ32);
        term_d = OneQ32;
        k_d    = 5'd1;
        pow_d  = '0;
        v_d    = '0;
      end
      OP_SER_MUL_DIV: begin
        div_num_d = {prod[40:8], 9'd0};
        div_den_d = {27'd0, k_q};
        div_rem_d = '0;
        div_cnt_d = 6'd33;
      end
      OP_SER_ACC: begin
        term_d = quo;
        if (k_q[0]) begin
          acc_d = acc_q - 35'(quo);
        end else begin
          acc_d = acc_q + 35'(quo);
        end
        k_d = k_q + 5'd1;
      end
      OP_CLAMP: begin
        v_d = acc_q[34] ? 33'd0 : acc_q[32:0];
      end
      OP_E1_SQ: begin
        e1_d = prod[63:32];
      end
      OP_POW: begin
        v_d   = prod[64:32];
        pow_d = pow_q + 5'd1;
      end
      OP_EXP_WR: begin
        sum_d = sum_q + 32'(v_q[32:7]);
        cls_d = cls_last ? '0 : cls_q + AW'(1);
      end
      OP_PROB_START: begin
        div_num_d = {rd_exp_q, 16'd0};
        div_den_d = sum_q;
        div_rem_d = '0;
        div_cnt_d = 6'd42;
      end
      OP_EMIT: begin
        res_valid_d = 1'b1;
        prob_d      = (div_num_q[41:16] != '0) ? 16'hFFFF : div_num_q[15:0];
        cidx_d      = 4'(cls_q);
        last_d      = cls_last;
        cls_d       = cls_last ? '0 : cls_q + AW'(1);
        if (cls_last) begin
          largest_d = 16'sh8000;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= NumClassesRst;
      recv_q        <= '0;
      cls_q         <= '0;
      largest_q     <= 16'sh8000;
      sum_q         <= '0;
      k_q           <= 5'd1;
      n_q           <= '0;
      pow_q         <= '0;
      div_cnt_q     <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_classes_q <= cfg_wdata_i;
      end
      recv_q      <= recv_d;
      cls_q       <= cls_d;
      largest_q   <= largest_d;
      sum_q       <= sum_d;
      k_q         <= k_d;
      n_q         <= n_d;
      pow_q       <= pow_d;
      div_cnt_q   <= div_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    term_q    <= term_d;
    v_q       <= v_d;
    e1_q      <= e1_d;
    m_q       <= m_d;
    div_num_q <= div_num_d;
    div_den_q <= div_den_d;
    div_rem_q <= div_rem_d;
    prob_q    <= prob_d;
    cidx_q    <= cidx_d;
    last_q    <= last_d;
  end

  // Score store: written on accept, read through a registered output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT) begin
      score_mem[recv_q[AW-1:0]] <= score_i;
    end
    if (cmd_i.op == OP_EXP_RD) begin
      rd_score_q <= score_mem[cls_q];
    end
  end

  // Exponential store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EXP_WR) begin
      exp_mem[cls_q] <= v_q[32:7];
    end
    if (cmd_i.op == OP_PROB_RD) begin
      rd_exp_q <= exp_mem[cls_q];
    end
  end

  assign status_o.inst_done = (recv_inc >= count);
  assign status_o.div_idle  = (div_cnt_q == 6'd0);
  assign status_o.k_last    = (k_q == 5'd16);
  assign status_o.n_big     = (n_q[7:5] != 3'd0);
  assign status_o.pow_done  = (pow_q == n_q[4:0]);
  assign status_o.cls_last  = cls_last;

  assign result_valid_o = res_valid_q;
  assign probability_o  = prob_q;
  assign class_index_o  = cidx_q;
  assign last_class_o   = last_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SER_MUL_DIV || cmd_i.op == OP_PROB_START) |-> (div_cnt_q == 6'd0))
    else $error("divider started while running");

  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PROB_START) |-> (sum_q != 32'd0))
    else $error("normalizing with an empty sum");

  a_last_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_class_o) |=> !result_valid_o)
    else $error("word strobed right after last class");

  a_acc_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_CLAMP) |-> !acc_q[34])
    else $error("series accumulator went negative");

endmodule

### hw/rtl/softmax_normalizer.sv
// Top level: softmax over the class scores of one instance.
//
//  channel   direction  handshake                 payload
//  config    in         cfg_we_i                  cfg_wdata_i (num_classes)
//  score     in         start (taken when !busy)  score_i (signed Q8.8)
//  result    out        result_valid_o strobe     probability_o, class_index_o, last_class_o
//
// Score words are accepted back to back while an instance fills. The word that
// completes an instance starts a sequenced pass: each class costs a store read and
// a load, 16 series terms (each a multiply, a bit-serial divide by the term index
// and an accumulate), and one exp(-1) multiply per unit of integer difference (up
// to 31); a class 32 or more below the largest skips the series and the multiplies.
// Then each class is divided by the sum in the same divider and strobed out. After
// reset the block builds exp(-1) with busy high. Results cannot be stalled; each
// strobe lasts one cycle.
`timescale 1ns / 1ps
module softmax_normalizer
  import smx_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = MaxClassesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  // score words
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] score_i,
  // result words
  output logic               result_valid_o,
  output logic [15:0]        probability_o,
  output logic [3:0]         class_index_o,
  output logic               last_class_o
);

  // Command and status between the sequencer and the datapath.
  smx_cmd_t    cmd;
  smx_status_t status;

  // Sequencer: boot pass for exp(-1), then fill, exponentials, normalize.
  smx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Datapath: stores, series/power unit, divider and the result register.
  smx_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .score_i        (score_i),
    .result_valid_o (result_valid_o),
    .probability_o  (probability_o),
    .class_index_o  (class_index_o),
    .last_class_o   (last_class_o)
  );

endmodule

### bench/softmax_normalizer_tb.sv
// Testbench for softmax_normalizer: random and directed scores against a softmax predictor.
`timescale 1ns / 1ps
module softmax_normalizer_tb;
  import smx_pkg::*;

  localparam int unsigned MaxCls = 16;
  // Longest quiet stretch: the exp pass over all 16 classes, which runs before any strobe.
  localparam int unsigned QuietLimit = 60000;
  localparam int unsigned SettleCycles = 700;

  typedef struct packed {
    logic [15:0] probability;
    logic [3:0]  class_index;
    logic        last_class;
  } prob_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [4:0]         cfg_wdata_i;
  logic               start;
  logic               busy;
  logic signed [15:0] score_i;
  logic               result_valid_o;
  logic [15:0]        probability_o;
  logic [3:0]         class_index_o;
  logic               last_class_o;

  softmax_normalizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .score_i       (score_i),
    .result_valid_o(result_valid_o),
    .probability_o (probability_o),
    .class_index_o (class_index_o),
    .last_class_o  (last_class_o)
  );

  // Stimulus and expectation stores.
  logic signed [15:0] score_queue[$];
  prob_word_t         prob_queue[$];

  // Predictor state: shadow of the block's instance buffer and class-count register.
  logic signed [15:0] score_buf[MaxCls];
  int unsigned        scores_in;
  int                 top_score;
  logic [4:0]         class_cfg;

  int unsigned sent_cnt, taken_cnt, word_cnt, inst_cnt, mismatches, quiet;
  int unsigned idle_pct;

  // exp(-f) for f in Q0.32, truncated series through the 16th term.
  function automatic logic [63:0] exp_frac_q32(logic [63:0] f);
    longint      acc;
    logic [63:0] term;
    acc  = 64'sh1_0000_0000;
    term = 64'h1_0000_0000;
    for (int k = 1; k <= 16; k++) begin
      term = (term * f) >> 32;
      term = term / k;
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  // exp(-d/256) in Q0.25; d is a Q8.8 distance below the largest score.
  function automatic logic [31:0] exp_q25(logic [31:0] d);
    logic [63:0] half, e1, v;
    int unsigned n;
    n = d >> 8;
    if (n >= 32) return 0;
    half = exp_frac_q32(64'h8000_0000);
    e1   = (half * half) >> 32;
    v    = exp_frac_q32(64'(d & 255) << 24);
    for (int i = 0; i < n; i++) v = (v * e1) >> 32;
    return 32'(v >> 7);
  endfunction

  // Take one score word; on instance completion queue one probability per class.
  task automatic take_score(logic signed [15:0] s);
    int unsigned cnt;
    logic [31:0] sum, e;
    logic [63:0] p;
    prob_word_t  w;
    cnt = class_cfg;
    if (cnt < 2) cnt = 2;
    if (cnt > MaxCls) cnt = MaxCls;
    if (scores_in < MaxCls) score_buf[scores_in] = s;
    scores_in = (scores_in + 1) & 31;
    if (int'(s) > top_score) top_score = s;
    if (scores_in < cnt) return;
    sum = 0;
    for (int i = 0; i < cnt; i++) sum += exp_q25(32'(top_score - int'(score_buf[i])));
    for (int i = 0; i < cnt; i++) begin
      e = exp_q25(32'(top_score - int'(score_buf[i])));
      p = (sum != 0) ? ((64'(e) << 16) / sum) : 0;
      if (p > 65535) p = 65535;
      w.probability = p[15:0];
      w.class_index = i[3:0];
      w.last_class  = (i + 1 == cnt);
      prob_queue.insert(prob_queue.size(), w);
    end
    inst_cnt++;
    scores_in = 0;
    top_score = -32768;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: hold a word until taken, then advance or idle at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      score_i <= '0;
    end else if (start && taken_cnt != sent_cnt) begin
      // hold: the current word is still waiting for !busy
    end else if (score_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      score_i <= score_queue.pop_front();
      sent_cnt++;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: mirror config writes, predict on accepted scores, check each strobe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) class_cfg = cfg_wdata_i;
      if (start && !busy) begin
        taken_cnt++;
        take_score(score_i);
      end
      if (result_valid_o) begin
        word_cnt++;
        if (prob_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: prob=%0d class=%0d last=%0b",
                     probability_o, class_index_o, last_class_o);
        end else begin
          prob_word_t w;
          w = prob_queue.pop_front();
          if (w.probability !== probability_o || w.class_index !== class_index_o ||
              w.last_class !== last_class_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp prob=%0d class=%0d last=%0b, %s",
                       w.probability, w.class_index, w.last_class,
                       $sformatf("got prob=%0d class=%0d last=%0b",
                                 probability_o, class_index_o, last_class_o));
          end
        end
      end
      // Watchdog over cycles in which no word moves either way.
      if ((start && !busy) || result_valid_o) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Write the class count; the block is idle here.
  task automatic write_classes(logic [4:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Drain: wait for every queued word to be taken and every expected result to arrive.
  task automatic drain();
    wait (score_queue.size() == 0 && taken_cnt == sent_cnt);
    wait (prob_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    wait (!busy);
  endtask

  // Score near a common base so probabilities spread; some fully random.
  function automatic logic signed [15:0] rand_score(int base, int spread);
    int v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  initial begin
    int unsigned random_items, ncls, spread, base, reps;
    random_items = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = NumClassesRst;
    sent_cnt = 0; taken_cnt = 0; word_cnt = 0; inst_cnt = 0;
    mismatches = 0; quiet = 0; idle_pct = 14;
    scores_in = 0; top_score = -32768; class_cfg = NumClassesRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: two classes at reset count, equal scores and both extremes.
    score_queue = '{16'sd0, 16'sd0, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF};
    drain();
    // Full width: sixteen classes with edge and fractional values.
    write_classes(5'd16);
    score_queue = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sh00FF, 16'sh0100, -16'sh0001,
                    16'sh7F00, 16'sh7EFF, 16'sh5555, -16'sh5556, 16'sh0080, 16'sh7FFE,
                    16'sh1234, -16'sh1234, 16'sh6000, 16'sh7001};
    drain();
    // Integer difference of 31 versus 32: just inside and just past the zero cutoff.
    write_classes(5'd3);
    score_queue = '{16'sd0, -16'sd7937, -16'sd8192};
    drain();
    // Out-of-range counts act as the nearest legal value.
    write_classes(5'd0);
    score_queue = '{16'sd100, 16'sd356};
    drain();
    write_classes(5'd1);
    score_queue = '{-16'sd5, 16'sd5};
    drain();
    write_classes(5'd31);
    for (int i = 0; i < 16; i++) score_queue.insert(score_queue.size(), 16'(i * 97 - 700));
    drain();
    // Count lowered mid-instance: the next word completes it with the new count.
    write_classes(5'd6);
    score_queue = '{16'sd300, -16'sd300, 16'sd900};
    drain();
    write_classes(5'd2);
    score_queue = '{16'sd50};
    drain();

    // Random phases: sender idling light, then heavy, then none.
    while (random_items < 250) begin
      idle_pct = (random_items < 84) ? 14 : (random_items < 167) ? 82 : 0;
      case ($urandom_range(9))
        0:       ncls = 16;
        1:       ncls = $urandom_range(31);
        2, 3:    ncls = $urandom_range(5, 10);
        default: ncls = $urandom_range(2, 4);
      endcase
      write_classes(5'(ncls));
      if (ncls < 2) ncls = 2;
      if (ncls > MaxCls) ncls = MaxCls;
      reps = $urandom_range(1, 4);
      for (int j = 0; j < int'(reps * ncls); j++) begin
        if (j % ncls == 0) begin
          base   = $urandom;
          spread = 1 << $urandom_range(4, 13);
        end
        score_queue.insert(score_queue.size(),
                           rand_score(int'(16'(base)) - 32768 + 32768 * 0, spread));
        random_items++;
      end
      // Sometimes leave a partial instance open across the next count change.
      if ($urandom_range(4) == 0) begin
        score_queue.insert(score_queue.size(), 16'($urandom));
        random_items++;
      end
      drain();
    end

    wait (prob_queue.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d score words, %0d instances, %0d probability words",
             taken_cnt, inst_cnt, word_cnt);
    $display("class counts 0..31 incl. out-of-range, extremes, cutoff, mid-instance change");
    if (mismatches == 0 && prob_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### softmax_normalizer.f
hw/rtl/smx_pkg.sv
hw/rtl/smx_ctrl.sv
hw/rtl/smx_datapath.sv
hw/rtl/softmax_normalizer.sv
bench/softmax_normalizer_tb.sv
